// ===== rtl/lwt_pkg.sv =====
// ----------------------------------------------------------------------------
// lwt_pkg
// Shared types and codes of the lock wait table: request and response
// payloads, the stored waiter entry and the command and status codes.
// ----------------------------------------------------------------------------
package lwt_pkg;

  // command codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // one request transfer
  typedef struct packed {
    logic        command;
    logic [7:0]  lock_descriptor;
    logic [5:0]  process_id;
    logic [7:0]  wait_priority;
    logic        access_kind;
    logic [31:0] wait_stamp;
  } lwt_req_t;

  // one response transfer
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot;
  } lwt_rsp_t;

  // one waiter slot as stored in the entry memory
  typedef struct packed {
    logic        valid;
    logic [5:0]  process;
    logic [7:0]  priority_lvl;
    logic        access;
    logic [31:0] stamp;
  } lwt_entry_t;

endpackage

// ===== rtl/lwt_count_store.sv =====
// ----------------------------------------------------------------------------
// lwt_count_store
// Fill count memory, one word per lock. A valid flop per word, cleared by
// reset, makes a never-written word read as zero.
// ----------------------------------------------------------------------------
module lwt_count_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned W     = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i
);

  logic [W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [W-1:0]     rdata_q;
  logic             rvld_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // per-word valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/lwt_entry_store.sv =====
// ----------------------------------------------------------------------------
// lwt_entry_store
// Waiter entry memory, one word per slot of every lock row, one write and
// one registered read port.
// ----------------------------------------------------------------------------
module lwt_entry_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                clk_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output lwt_pkg::lwt_entry_t rdata_o,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  lwt_pkg::lwt_entry_t wdata_i
);
  import lwt_pkg::*;

  lwt_entry_t mem [DEPTH];
  lwt_entry_t rdata_q;

  // storage array and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lock_wait_table.sv =====
// ----------------------------------------------------------------------------
// lock_wait_table
// Per-lock wait table: append stores a waiter at the row fill count, remove
// scans the row for the lowest valid slot with a matching process id.
// An append, and a remove on an empty row, finish after the count read;
// a remove scans up to the row fill count, reading the entry memory one
// slot per cycle.
// One item at a time; busy stays high until the result strobe is issued.
// Reset clears all fill counts at once; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module lock_wait_table #(
  parameter int unsigned LOCK_COUNT     = 64,
  parameter int unsigned SLOTS_PER_LOCK = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lwt_pkg::lwt_req_t req_i,
  output logic              done_o,
  output lwt_pkg::lwt_rsp_t rsp_o
);
  import lwt_pkg::*;

  localparam int unsigned LW    = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int unsigned CW    = $clog2(SLOTS_PER_LOCK + 1);
  localparam int unsigned DEPTH = LOCK_COUNT * SLOTS_PER_LOCK;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDCNT = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_SCAN  = 2'd3;

  logic [1:0]    state_q, state_d;
  lwt_req_t      req_q;
  logic [LW-1:0] lock_q, lock_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] ridx_q, ridx_d;
  logic [CW-1:0] chk_idx_q, chk_idx_d;
  logic          chk_v_q, chk_v_d;
  logic          done_q, done_d;
  lwt_rsp_t      rsp_q, rsp_d;

  logic [8:0]    rem;
  logic [CW-1:0] cnt_rd;
  logic          cnt_re, cnt_we;
  logic [CW-1:0] cnt_wdata;
  logic          ent_re, ent_we;
  logic [AW-1:0] ent_raddr, ent_waddr;
  lwt_entry_t    ent_rd, ent_wdata;
  logic          hit;

  // lock descriptor modulo lock count, as a constant lookup table
  always_comb begin
    rem = '0;
    for (int v = 0; v < 256; v++) begin
      if (req_i.lock_descriptor == 8'(v)) begin
        rem = 9'(v % LOCK_COUNT);
      end
    end
  end

  assign hit = chk_v_q && ent_rd.valid && (ent_rd.process == req_q.process_id);

  // sequencer: count read, evaluate, then slot scan for removes
  always_comb begin
    state_d   = state_q;
    lock_d    = lock_q;
    base_d    = base_q;
    cnt_d     = cnt_q;
    ridx_d    = ridx_q;
    chk_idx_d = chk_idx_q;
    chk_v_d   = 1'b0;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    cnt_re    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rd + CW'(1);
    ent_re    = 1'b0;
    ent_raddr = base_q + AW'(ridx_q);
    ent_we    = 1'b0;
    ent_waddr = base_q + AW'(cnt_rd);
    ent_wdata = '{valid: 1'b1, process: req_q.process_id,
                  priority_lvl: req_q.wait_priority,
                  access: req_q.access_kind, stamp: req_q.wait_stamp};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          lock_d  = LW'(rem);
          state_d = S_RDCNT;
        end
      end
      S_RDCNT: begin
        cnt_re  = 1'b1;
        base_d  = AW'(lock_q * SLOTS_PER_LOCK);
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cnt_d  = cnt_rd;
        ridx_d = '0;
        if (req_q.command == CMD_APPEND) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cnt_rd >= CW'(SLOTS_PER_LOCK)) begin
            rsp_d = '{status: ST_FULL, slot: 6'd0};
          end else begin
            ent_we = 1'b1;
            cnt_we = 1'b1;
            rsp_d  = '{status: ST_OK, slot: 6'(cnt_rd)};
          end
        end else if (cnt_rd == '0) begin
          done_d  = 1'b1;
          rsp_d   = '{status: ST_NOT_FOUND, slot: 6'd0};
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one slot read per cycle, check the previous one
        if (ridx_q < cnt_q) begin
          ent_re    = 1'b1;
          ridx_d    = ridx_q + CW'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = ridx_q;
        end
        if (hit) begin
          ent_we    = 1'b1;
          ent_waddr = base_q + AW'(chk_idx_q);
          ent_wdata = '0;
          done_d    = 1'b1;
          chk_v_d   = 1'b0;
          rsp_d     = '{status: ST_OK, slot: 6'(chk_idx_q)};
          state_d   = S_IDLE;
        end else if (chk_v_q && (chk_idx_q + CW'(1) == cnt_q)) begin
          done_d  = 1'b1;
          chk_v_d = 1'b0;
          rsp_d   = '{status: ST_NOT_FOUND, slot: 6'd0};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chk_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_v_q <= chk_v_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    lock_q    <= lock_d;
    base_q    <= base_d;
    cnt_q     <= cnt_d;
    ridx_q    <= ridx_d;
    chk_idx_q <= chk_idx_d;
    rsp_q     <= rsp_d;
  end

  // fill counts
  lwt_count_store #(
    .DEPTH (LOCK_COUNT),
    .AW    (LW),
    .W     (CW)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (cnt_re),
    .raddr_i (lock_q),
    .rdata_o (cnt_rd),
    .we_i    (cnt_we),
    .waddr_i (lock_q),
    .wdata_i (cnt_wdata)
  );

  // waiter entries
  lwt_entry_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_entry (
    .clk_i   (clk_i),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rd),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
